// ===== src/peos_pkg.sv =====
// ============================================================================
// peos_pkg
// Shared types and constants for the pinned entry ordered store: the
// transaction structs, the command and eviction codes, and the cell control
// and chain link structs.
// ============================================================================
package peos_pkg;

    // Command codes carried in the cmd field.
    localparam logic [2:0] CMD_ADD         = 3'd0;
    localparam logic [2:0] CMD_DELETE      = 3'd1;
    localparam logic [2:0] CMD_MARK_READ   = 3'd2;
    localparam logic [2:0] CMD_GET         = 3'd3;
    localparam logic [2:0] CMD_CLEAR_CHGD  = 3'd4;

    // Eviction report codes.
    localparam logic [1:0] EVICT_NONE      = 2'd0;
    localparam logic [1:0] EVICT_NONPERS   = 2'd1;
    localparam logic [1:0] EVICT_OLDEST    = 2'd2;

    // Bit positions inside the three-bit flag word.
    localparam int FLAG_READ_BIT    = 0;
    localparam int FLAG_SIGNED_BIT  = 1;
    localparam int FLAG_PERSIST_BIT = 2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  index;
        logic [31:0] timestamp;
        logic [47:0] origin_id;
        logic [7:0]  hop_count;
        logic        sig_mark;
        logic        pin_mark;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] entry_timestamp;
        logic [47:0] entry_sender;
        logic [7:0]  entry_path_len;
        logic        entry_read;
        logic        entry_signed;
        logic        entry_persistent;
        logic [5:0]  stored_count;
        logic [5:0]  unread_count;
        logic        changed_flag;
        logic [1:0]  eviction_kind;
    } rsp_t;

    // One stored entry.
    typedef struct packed {
        logic [31:0] time_stamp;
        logic [47:0] sender;
        logic [7:0]  path;
        logic [2:0]  flags;
    } entry_t;

    // Control broadcast to every cell; all strobes are already qualified.
    typedef struct packed {
        logic        add;
        logic        evict;
        logic        del;
        logic        mark;
        logic        get;
        logic        none_found;
        logic [7:0]  index;
        logic [7:0]  append_pos;
        logic [7:0]  fill;
        entry_t      new_entry;
    } cell_ctl_t;

    // Signals that ripple from the oldest cell towards the youngest.
    typedef struct packed {
        logic        found;
        logic        gap;
        entry_t      pick;
    } link_t;

endpackage

// ===== src/peos_cell.sv =====
// ============================================================================
// peos_cell
// One position of the store. Holds a single entry, takes its younger
// neighbor's entry when a gap closes below it, and joins the victim search,
// gap and pick chains.
// ============================================================================
module peos_cell #(
    parameter int POS = 0
) (
    input  logic               clk,
    input  peos_pkg::cell_ctl_t ctl,
    input  peos_pkg::entry_t   younger,
    output peos_pkg::entry_t   entry,
    input  peos_pkg::link_t    link_in,
    output peos_pkg::link_t    link_out
);

    peos_pkg::entry_t entry_reg;
    peos_pkg::entry_t entry_next;

    logic [7:0] pos_c;
    logic       valid;
    logic       nonpers;
    logic       idx_hit;
    logic       start;
    logic       shift;
    logic       pick;

    assign pos_c   = 8'(POS);
    assign valid   = pos_c < ctl.fill;
    assign nonpers = valid && !entry_reg.flags[peos_pkg::FLAG_PERSIST_BIT];
    assign idx_hit = ctl.index == pos_c;

    // The removed position is either the indexed one or the eviction victim.
    assign start = (ctl.del && idx_hit)
                 || (ctl.evict && nonpers && !link_in.found)
                 || (ctl.evict && ctl.none_found && (POS == 0));
    assign shift = link_in.gap || start;
    assign pick  = start || ((ctl.get || ctl.mark) && idx_hit);

    assign link_out.found = link_in.found || nonpers;
    assign link_out.gap   = shift;
    assign link_out.pick  = link_in.pick | (pick ? entry_reg : '0);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.add && (ctl.append_pos == pos_c))
        begin
            entry_next = ctl.new_entry;
        end
        else if (shift)
        begin
            entry_next = younger;
        end
        if (ctl.mark && idx_hit)
        begin
            entry_next.flags[peos_pkg::FLAG_READ_BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== src/pinned_entry_ordered_store.sv =====
// ============================================================================
// pinned_entry_ordered_store
// Ordered store of up to CAPACITY entries, oldest first, built as a row of
// entry cells that close gaps by moving entries one cell down in parallel.
// ============================================================================
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------
//  req     | in        | req_valid/req_stall | peos_pkg::req_t (command)
//  rsp     | out       | rsp_valid/rsp_stall | peos_pkg::rsp_t (result)
//
//  Every command has a capture step, which registers the transaction, and an
//  execute step, in which all cells update together and the result register
//  is loaded. The execute cycle is set by the ripple of the victim, gap and
//  pick chains through all CAPACITY cells.
//  Reset empties the store and clears the changed flag; cell contents are
//  not reset, since only positions below the fill count are ever read.
//  A stalled result holds the block in its execute cycle; a new command is
//  still taken while the previous result waits in the output register.
//
module pinned_entry_ordered_store #(
    parameter int CAPACITY = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  peos_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output peos_pkg::rsp_t   rsp
);

    localparam int FILL_W = $clog2(CAPACITY + 1);

    peos_pkg::state_t state_reg;
    peos_pkg::state_t state_next;
    peos_pkg::req_t   cmd_reg;
    peos_pkg::rsp_t   rsp_reg;
    peos_pkg::rsp_t   rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] unread_reg;
    logic [FILL_W-1:0] unread_next;
    logic             modified_reg;
    logic             modified_next;

    logic             exec_fire;
    logic             accept;
    logic [7:0]       fill8;
    logic             idx_ok;
    logic             full;
    logic             none_found;
    peos_pkg::entry_t picked;
    peos_pkg::cell_ctl_t ctl;
    logic [FILL_W+5:0] fill_ext;
    logic [FILL_W+5:0] unread_ext;

    peos_pkg::entry_t ents  [CAPACITY+1];
    peos_pkg::link_t  links [CAPACITY+1];

    // ------------------------------------------------------------------
    // Handshake. The input side is open only while no command is in
    // flight; the execute cycle fires once the result register is free.
    // ------------------------------------------------------------------
    assign req_stall = state_reg != peos_pkg::ST_IDLE;
    assign accept    = req_valid && !req_stall;
    assign exec_fire = (state_reg == peos_pkg::ST_EXEC) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            peos_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = peos_pkg::ST_EXEC;
                end
            end
            peos_pkg::ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = peos_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = peos_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Broadcast control for the cell row. Strobes are qualified by the
    // execute cycle, the indexed ones also by the index check, so a rejected
    // command leaves every cell untouched and picks nothing.
    // ------------------------------------------------------------------
    assign fill8  = 8'(fill_reg);
    assign idx_ok = cmd_reg.index < fill8;
    assign full   = fill_reg == FILL_W'(CAPACITY);

    always_comb
    begin
        ctl                      = '0;
        ctl.index                = cmd_reg.index;
        ctl.fill                 = fill8;
        ctl.append_pos           = full ? 8'(CAPACITY - 1) : fill8;
        ctl.none_found           = none_found;
        ctl.new_entry.time_stamp = cmd_reg.timestamp;
        ctl.new_entry.sender     = cmd_reg.origin_id;
        ctl.new_entry.path       = cmd_reg.hop_count;
        ctl.new_entry.flags      = '0;
        ctl.new_entry.flags[peos_pkg::FLAG_SIGNED_BIT]  = cmd_reg.sig_mark;
        ctl.new_entry.flags[peos_pkg::FLAG_PERSIST_BIT] = cmd_reg.pin_mark;
        if (exec_fire)
        begin
            ctl.add   = cmd_reg.cmd == peos_pkg::CMD_ADD;
            ctl.evict = (cmd_reg.cmd == peos_pkg::CMD_ADD) && full;
            ctl.del   = (cmd_reg.cmd == peos_pkg::CMD_DELETE) && idx_ok;
            ctl.mark  = (cmd_reg.cmd == peos_pkg::CMD_MARK_READ) && idx_ok;
            ctl.get   = (cmd_reg.cmd == peos_pkg::CMD_GET) && idx_ok;
        end
    end

    // ------------------------------------------------------------------
    // Cell row. Position 0 is the oldest entry. Chains start empty at the
    // oldest end; the youngest cell has nothing behind it to take over.
    // ------------------------------------------------------------------
    assign links[0]       = '0;
    assign ents[CAPACITY] = '0;

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        peos_cell #(
            .POS (k)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .younger  (ents[k+1]),
            .entry    (ents[k]),
            .link_in  (links[k]),
            .link_out (links[k+1])
        );
    end

    // No non-persistent entry anywhere means the oldest one is evicted.
    assign none_found = !links[CAPACITY].found;
    // The entry removed by delete or eviction, or the one read or marked.
    assign picked     = links[CAPACITY].pick;

    // ------------------------------------------------------------------
    // Counters, changed flag and the result.
    // ------------------------------------------------------------------
    always_comb
    begin
        fill_next     = fill_reg;
        unread_next   = unread_reg;
        modified_next = modified_reg;
        rsp_next      = '0;
        case (cmd_reg.cmd)
            peos_pkg::CMD_ADD:
            begin
                // A full store keeps its count: one out, one in.
                if (!full)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                unread_next = unread_reg + FILL_W'(1);
                if (full && !picked.flags[peos_pkg::FLAG_READ_BIT])
                begin
                    unread_next = unread_reg;
                end
                modified_next = 1'b1;
                rsp_next.accepted = 1'b1;
                if (full)
                begin
                    rsp_next.eviction_kind = none_found ? peos_pkg::EVICT_OLDEST
                                                        : peos_pkg::EVICT_NONPERS;
                end
                else
                begin
                    rsp_next.eviction_kind = peos_pkg::EVICT_NONE;
                end
            end
            peos_pkg::CMD_DELETE:
            begin
                if (idx_ok)
                begin
                    fill_next = fill_reg - FILL_W'(1);
                    if (!picked.flags[peos_pkg::FLAG_READ_BIT])
                    begin
                        unread_next = unread_reg - FILL_W'(1);
                    end
                    modified_next     = 1'b1;
                    rsp_next.accepted = 1'b1;
                end
            end
            peos_pkg::CMD_MARK_READ:
            begin
                if (idx_ok)
                begin
                    // Marking an entry that is already read changes nothing.
                    if (!picked.flags[peos_pkg::FLAG_READ_BIT])
                    begin
                        unread_next   = unread_reg - FILL_W'(1);
                        modified_next = 1'b1;
                    end
                    rsp_next.accepted = 1'b1;
                end
            end
            peos_pkg::CMD_GET:
            begin
                if (idx_ok)
                begin
                    rsp_next.accepted         = 1'b1;
                    rsp_next.entry_timestamp  = picked.time_stamp;
                    rsp_next.entry_sender     = picked.sender;
                    rsp_next.entry_path_len   = picked.path;
                    rsp_next.entry_read       = picked.flags[peos_pkg::FLAG_READ_BIT];
                    rsp_next.entry_signed     = picked.flags[peos_pkg::FLAG_SIGNED_BIT];
                    rsp_next.entry_persistent = picked.flags[peos_pkg::FLAG_PERSIST_BIT];
                end
            end
            peos_pkg::CMD_CLEAR_CHGD:
            begin
                modified_next     = 1'b0;
                rsp_next.accepted = 1'b1;
            end
            default:
            begin
                rsp_next.accepted = 1'b0;
            end
        endcase
        // Counts are reported modulo 64.
        fill_ext              = (FILL_W + 6)'(fill_next);
        unread_ext            = (FILL_W + 6)'(unread_next);
        rsp_next.stored_count = fill_ext[5:0];
        rsp_next.unread_count = unread_ext[5:0];
        rsp_next.changed_flag = modified_next;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (exec_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= peos_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            fill_reg      <= '0;
            unread_reg    <= '0;
            modified_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_fire)
            begin
                fill_reg     <= fill_next;
                unread_reg   <= unread_next;
                modified_reg <= modified_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req;
        end
        if (exec_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_unread_bound: assert property (@(posedge clk) disable iff (!rst_n)
        unread_reg <= fill_reg)
        else $error("unread count exceeds fill count");

    a_add_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && (cmd_reg.cmd == peos_pkg::CMD_ADD)) |=> (fill_reg != '0))
        else $error("store empty after an add");

    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == peos_pkg::ST_EXEC))
        else $error("result raised outside the execute cycle");

endmodule

// ===== sim/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the pinned entry ordered store. A small scoreboard
// keeps its own copy of the entry row, predicts every result from the
// commands that the block accepts, and compares each result field by field.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 32;
    localparam int ITEM_TARGET = 1550;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 20;

    // Phase flavors of the random command stream.
    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIXED = 2;
    localparam int PH_READS = 3;

    // Receiver stall styles.
    localparam int RS_NONE     = 0;
    localparam int RS_RANDOM   = 1;
    localparam int RS_PERIODIC = 2;
    localparam int RS_RUNS     = 3;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the entry row and holds the results still owed.
    // ------------------------------------------------------------------------
    class entry_store_board;
        peos_pkg::entry_t slots [CAPACITY];
        int unsigned      fill;
        bit               modified;
        peos_pkg::rsp_t   owed [$];
        int               errors;
        int               results_seen;
        int               adds;
        int               evict_unpinned;
        int               evict_pinned;
        int               gets_hit;
        int               rejected;
        int               peak_fill;

        function new();
            fill     = 0;
            modified = 1'b0;
            errors   = 0;
        endfunction

        // Drop the entry at pos and slide every younger entry one place down.
        function void remove_at(int unsigned pos);
            for (int unsigned k = pos; k + 1 < fill; k++)
            begin
                slots[k] = slots[k + 1];
            end
            fill--;
        endfunction

        function void note_command(peos_pkg::req_t c);
            peos_pkg::rsp_t r;
            int unsigned    victim;
            bit             found;
            int unsigned    unread;
            r      = '0;
            victim = 0;
            found  = 1'b0;
            unread = 0;
            case (c.cmd)
                peos_pkg::CMD_ADD:
                begin
                    if (fill >= CAPACITY)
                    begin
                        for (int unsigned k = 0; k < fill; k++)
                        begin
                            if (!found && !slots[k].flags[peos_pkg::FLAG_PERSIST_BIT])
                            begin
                                victim = k;
                                found  = 1'b1;
                            end
                        end
                        r.eviction_kind = found ? peos_pkg::EVICT_NONPERS
                                                : peos_pkg::EVICT_OLDEST;
                        if (found)
                            evict_unpinned++;
                        else
                            evict_pinned++;
                        remove_at(victim);
                    end
                    slots[fill].time_stamp = c.timestamp;
                    slots[fill].sender     = c.origin_id;
                    slots[fill].path       = c.hop_count;
                    slots[fill].flags      = '0;
                    slots[fill].flags[peos_pkg::FLAG_SIGNED_BIT]  = c.sig_mark;
                    slots[fill].flags[peos_pkg::FLAG_PERSIST_BIT] = c.pin_mark;
                    fill++;
                    modified   = 1'b1;
                    r.accepted = 1'b1;
                    adds++;
                end
                peos_pkg::CMD_DELETE:
                begin
                    if (c.index < fill)
                    begin
                        remove_at(c.index);
                        modified   = 1'b1;
                        r.accepted = 1'b1;
                    end
                end
                peos_pkg::CMD_MARK_READ:
                begin
                    if (c.index < fill)
                    begin
                        if (!slots[c.index].flags[peos_pkg::FLAG_READ_BIT])
                        begin
                            slots[c.index].flags[peos_pkg::FLAG_READ_BIT] = 1'b1;
                            modified = 1'b1;
                        end
                        r.accepted = 1'b1;
                    end
                end
                peos_pkg::CMD_GET:
                begin
                    if (c.index < fill)
                    begin
                        r.entry_timestamp  = slots[c.index].time_stamp;
                        r.entry_sender     = slots[c.index].sender;
                        r.entry_path_len   = slots[c.index].path;
                        r.entry_read       = slots[c.index].flags[peos_pkg::FLAG_READ_BIT];
                        r.entry_signed     = slots[c.index].flags[peos_pkg::FLAG_SIGNED_BIT];
                        r.entry_persistent = slots[c.index].flags[peos_pkg::FLAG_PERSIST_BIT];
                        r.accepted         = 1'b1;
                        gets_hit++;
                    end
                end
                peos_pkg::CMD_CLEAR_CHGD:
                begin
                    modified   = 1'b0;
                    r.accepted = 1'b1;
                end
                default:
                begin
                end
            endcase
            for (int unsigned k = 0; k < fill; k++)
            begin
                if (!slots[k].flags[peos_pkg::FLAG_READ_BIT])
                    unread++;
            end
            r.stored_count = fill[5:0];
            r.unread_count = unread[5:0];
            r.changed_flag = modified;
            if (!r.accepted)
                rejected++;
            if (fill > peak_fill)
                peak_fill = fill;
            owed.push_back(r);
        endfunction

        task report(string what);
            $display("ERROR at %0t ns, result %0d: %s", $time, results_seen, what);
            errors++;
        endtask

        task compare_field(string label, logic [47:0] got, logic [47:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, expected %0h", label, got, want));
        endtask

        task check_result(peos_pkg::rsp_t got);
            peos_pkg::rsp_t want;
            results_seen++;
            if (owed.size() == 0)
            begin
                report("result arrived with no command outstanding");
                return;
            end
            want = owed.pop_front();
            compare_field("accepted",         got.accepted,         want.accepted);
            compare_field("entry_timestamp",  got.entry_timestamp,  want.entry_timestamp);
            compare_field("entry_sender",     got.entry_sender,     want.entry_sender);
            compare_field("entry_path_len",   got.entry_path_len,   want.entry_path_len);
            compare_field("entry_read",       got.entry_read,       want.entry_read);
            compare_field("entry_signed",     got.entry_signed,     want.entry_signed);
            compare_field("entry_persistent", got.entry_persistent, want.entry_persistent);
            compare_field("stored_count",     got.stored_count,     want.stored_count);
            compare_field("unread_count",     got.unread_count,     want.unread_count);
            compare_field("changed_flag",     got.changed_flag,     want.changed_flag);
            compare_field("eviction_kind",    got.eviction_kind,    want.eviction_kind);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block under test. Every input starts at a known
    // value so that nothing undefined reaches the block before reset ends.
    // ------------------------------------------------------------------------
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           rsp_stall = 1'b0;
    peos_pkg::req_t req       = '0;
    logic           req_stall;
    logic           rsp_valid;
    peos_pkg::rsp_t rsp;

    entry_store_board board = new();
    int               cycles = 0;
    int               sent   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pinned_entry_ordered_store #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // The watchdog bounds the whole run. Its limit covers every command
    // meeting the longest sender gap, the longest receiver stall run and
    // the capture and execute steps, with a wide margin on top.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results owed", cycles,
                     board.owed.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side. The receiver stalls in one of several styles, drawn anew
    // at random as the run goes on, so that some stretches see no stall at all
    // and others hold a result through long stall runs. Values are read at the
    // clock edge before any update of that edge takes effect, so there is no race.
    // ------------------------------------------------------------------------
    int   stall_style = RS_NONE;
    int   stall_run   = 0;
    logic stall_next;

    always @(posedge clk)
    begin
        if (cycles % 256 == 0)
            stall_style = $urandom_range(RS_NONE, RS_RUNS);
        stall_next = 1'b0;
        case (stall_style)
            RS_RANDOM:   stall_next = ($urandom_range(0, 2) == 0);
            RS_PERIODIC: stall_next = ((cycles % 7) < 3);
            RS_RUNS:
            begin
                if (stall_run > 0)
                begin
                    stall_run  = stall_run - 1;
                    stall_next = 1'b1;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    stall_run  = $urandom_range(3, 15);
                    stall_next = 1'b1;
                end
            end
            default:     stall_next = 1'b0;
        endcase
        rsp_stall <= stall_next;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_result(rsp);
    end

    // ------------------------------------------------------------------------
    // Command side. A command is presented at a rising edge and held until
    // the edge at which req_stall is low; that edge is the handshake, and the
    // scoreboard learns of the transaction there. Valid stays high between
    // back-to-back transactions; only an explicit gap lowers it.
    // ------------------------------------------------------------------------
    task automatic issue(input peos_pkg::req_t c);
        req       <= c;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        board.note_command(c);
        sent++;
    endtask

    task automatic pause(input int n);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off new commands until every owed result has been taken. At least
    // one edge passes so that valid is never lowered and raised in one step.
    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.owed.size() != 0);
    endtask

    function automatic peos_pkg::req_t add_cmd(logic [31:0] ts, logic [47:0] snd,
                                               logic [7:0] path, logic sig, logic pers);
        peos_pkg::req_t c;
        c           = '0;
        c.cmd       = peos_pkg::CMD_ADD;
        c.index     = 8'($urandom);
        c.timestamp = ts;
        c.origin_id = snd;
        c.hop_count = path;
        c.sig_mark  = sig;
        c.pin_mark  = pers;
        return c;
    endfunction

    // Non-add commands still carry random add fields, which the block must
    // ignore.
    function automatic peos_pkg::req_t index_cmd(logic [2:0] code, logic [7:0] idx);
        peos_pkg::req_t c;
        logic [63:0]    wide;
        wide          = {$urandom, $urandom};
        c             = add_cmd($urandom, wide[47:0], 8'($urandom), 1'($urandom),
                                1'($urandom));
        c.cmd         = code;
        c.index       = idx;
        return c;
    endfunction

    // Mostly a position that holds an entry; otherwise any index, which is
    // usually out of range and sometimes lands exactly on the fill count.
    function automatic logic [7:0] pick_index();
        if (board.fill > 0 && $urandom_range(0, 9) < 8)
            return 8'($urandom_range(0, board.fill - 1));
        if ($urandom_range(0, 3) == 0)
            return 8'(board.fill);
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic peos_pkg::req_t random_cmd(int flavor, int persist_pct);
        int          roll;
        int          add_pct;
        int          del_pct;
        logic [63:0] wide;
        roll = $urandom_range(0, 99);
        case (flavor)
            PH_FILL:  begin add_pct = 70; del_pct = 5;  end
            PH_DRAIN: begin add_pct = 10; del_pct = 50; end
            PH_MIXED: begin add_pct = 35; del_pct = 15; end
            default:  begin add_pct = 25; del_pct = 10; end
        endcase
        if (roll < add_pct)
        begin
            wide = {$urandom, $urandom};
            return add_cmd($urandom, wide[47:0], 8'($urandom), 1'($urandom),
                           $urandom_range(0, 99) < persist_pct);
        end
        if (roll < add_pct + del_pct)
            return index_cmd(peos_pkg::CMD_DELETE, pick_index());
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return index_cmd(peos_pkg::CMD_MARK_READ, pick_index());
        if (roll < 75)
            return index_cmd(peos_pkg::CMD_GET, pick_index());
        if (roll < 90)
            return index_cmd(peos_pkg::CMD_CLEAR_CHGD, 8'($urandom));
        // Unused command codes, which the block must reject.
        return index_cmd(3'($urandom_range(5, 7)), 8'($urandom));
    endfunction

    initial
    begin
        int flavor;
        int persist_pct;
        int phase_len;
        int burst_left;
        int gap_max;
        int phase_count;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed opening: rejections on an empty store, the unused codes,
        // adds with all-zero and all-one fields, a get just past the end,
        // marking an entry that is already read, and deletes at both ends.
        issue(index_cmd(peos_pkg::CMD_CLEAR_CHGD, 8'd0));
        issue(index_cmd(peos_pkg::CMD_GET, 8'd0));
        issue(index_cmd(peos_pkg::CMD_DELETE, 8'd0));
        issue(index_cmd(peos_pkg::CMD_MARK_READ, 8'd255));
        issue(index_cmd(3'd5, 8'd0));
        issue(index_cmd(3'd6, 8'd255));
        issue(index_cmd(3'd7, 8'd1));
        issue(add_cmd('1, '1, '1, 1'b1, 1'b1));
        issue(add_cmd('0, '0, '0, 1'b0, 1'b0));
        issue(add_cmd(32'h8000_0001, 48'h8000_0000_0001, 8'h81, 1'b1, 1'b0));
        issue(index_cmd(peos_pkg::CMD_GET, 8'd0));
        issue(index_cmd(peos_pkg::CMD_GET, 8'd1));
        issue(index_cmd(peos_pkg::CMD_GET, 8'd2));
        issue(index_cmd(peos_pkg::CMD_GET, 8'd3));
        issue(index_cmd(peos_pkg::CMD_MARK_READ, 8'd1));
        issue(index_cmd(peos_pkg::CMD_MARK_READ, 8'd1));
        issue(index_cmd(peos_pkg::CMD_CLEAR_CHGD, 8'd0));
        issue(index_cmd(peos_pkg::CMD_MARK_READ, 8'd1));
        issue(index_cmd(peos_pkg::CMD_GET, 8'd1));
        issue(index_cmd(peos_pkg::CMD_DELETE, 8'd2));
        issue(index_cmd(peos_pkg::CMD_DELETE, 8'd0));
        issue(index_cmd(peos_pkg::CMD_GET, 8'd0));
        issue(index_cmd(peos_pkg::CMD_GET, 8'd255));

        // Random part in phases. The first two phases fill the store past
        // capacity, once with every entry pinned so that the oldest entry is
        // evicted, and once with a mix so that unpinned entries are evicted.
        phase_count = 0;
        while (sent < ITEM_TARGET)
        begin
            if (phase_count == 0)
            begin
                flavor      = PH_FILL;
                persist_pct = 100;
                phase_len   = 80;
            end
            else if (phase_count == 1)
            begin
                flavor      = PH_FILL;
                persist_pct = 40;
                phase_len   = 100;
            end
            else
            begin
                flavor = $urandom_range(PH_FILL, PH_READS);
                case ($urandom_range(0, 3))
                    0:       persist_pct = 0;
                    1:       persist_pct = 20;
                    2:       persist_pct = 60;
                    default: persist_pct = 100;
                endcase
                phase_len = $urandom_range(20, 120);
            end
            // Some phases run with no sender gaps at all.
            gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 20);
            burst_left = $urandom_range(1, 24);
            for (int n = 0; n < phase_len && sent < ITEM_TARGET; n++)
            begin
                issue(random_cmd(flavor, persist_pct));
                burst_left--;
                if (burst_left == 0)
                begin
                    pause($urandom_range(0, gap_max));
                    burst_left = $urandom_range(1, 24);
                end
            end
            // The sender waits for every owed result after the first phase
            // and now and then afterwards.
            if (phase_count == 0 || $urandom_range(0, 3) == 0)
                drain_results();
            phase_count++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d commands in %0d phases: %0d adds, %0d evictions of unpinned",
                 sent, phase_count, board.adds, board.evict_unpinned);
        $display("entries, %0d of the oldest pinned entry, %0d gets hit, %0d rejected, peak %0d.",
                 board.evict_pinned, board.gets_hit, board.rejected, board.peak_fill);
        if (board.errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches found", board.errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
